### hw/rtl/cqpm_pkg.sv
// ----------------------------------------------------------------------------
// cqpm_pkg: shared types and constants
// Field widths, fixed-point format and register indexes of the quantized
// partial-sum multiply-accumulate block.
// ----------------------------------------------------------------------------
package cqpm_pkg;

  // Item field widths
  localparam int ACT_W = 8;
  localparam int WGT_W = 8;
  localparam int VAR_W = 16;
  localparam int DOT_W = 20;

  // Fixed point: offsets and partial sums carry FRAC_BITS fraction bits
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = ACT_W + WGT_W;
  localparam int TERM_W    = PROD_W + FRAC_BITS + 1;
  localparam int PS_W      = 32;

  // Configuration registers
  localparam int GS_W      = 7;
  localparam int GC_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 1'b1;

  typedef logic signed [ACT_W-1:0] act_t;
  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef logic signed [VAR_W-1:0] var_t;
  typedef logic signed [DOT_W-1:0] dot_t;

endpackage

### hw/rtl/cqpm_in_if.sv
// ----------------------------------------------------------------------------
// cqpm_in_if: input element channel
// Valid/ready channel carrying one activation, weight and offset pair.
// ----------------------------------------------------------------------------
interface cqpm_in_if import cqpm_pkg::*; ();

  logic valid;
  logic ready;
  act_t activation;
  wgt_t weight_value;
  var_t var_plus;
  var_t var_minus;

  modport source (output valid, output activation, output weight_value,
                  output var_plus, output var_minus, input ready);
  modport sink   (input valid, input activation, input weight_value,
                  input var_plus, input var_minus, output ready);

endinterface

### hw/rtl/cqpm_out_if.sv
// ----------------------------------------------------------------------------
// cqpm_out_if: result channel
// Valid/ready channel carrying one dot product value.
// ----------------------------------------------------------------------------
interface cqpm_out_if import cqpm_pkg::*; ();

  logic valid;
  logic ready;
  dot_t dot_value;

  modport source (output valid, output dot_value, input ready);
  modport sink   (input valid, input dot_value, output ready);

endinterface

### hw/rtl/crossbar_quantized_psum_mac.sv
// ----------------------------------------------------------------------------
// crossbar_quantized_psum_mac: quantized partial-sum dot product
// Multiply-accumulate with per-sign offsets, group quantization and a
// running total of quantized groups.
// ----------------------------------------------------------------------------
// The block takes one element item per clock cycle unless a finished group
// cannot drain; the last group's closing element passes the input, group and
// result registers before its result leaves. Stage one registers the item;
// stage two multiplies, adds the offset and accumulates the partial sum, a
// loop that sets the rate; stage three quantizes a finished group and adds it
// to the running total; the result register holds the total until it is taken,
// while new items keep flowing in behind it until the group register fills.
// Group size 0 acts as 1; counts above the parameter limits act as the limit.
module crossbar_quantized_psum_mac
  import cqpm_pkg::*;
#(
  parameter int MAX_GROUP  = 64,
  parameter int MAX_GROUPS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cqpm_in_if.sink              in_ch,
  cqpm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SZW = $clog2(MAX_GROUP + 1);
  localparam int ECW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int GCW = $clog2(MAX_GROUPS + 1);
  localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int QD_W = PS_W + 2 - FRAC_BITS;

  // Configuration registers
  logic [GS_W-1:0] group_size_r;
  logic [GC_W-1:0] group_count_r;

  // Input stage
  logic v1_r;
  act_t a_r;
  wgt_t w_r;
  var_t vp_r;
  var_t vm_r;

  // Accumulate stage
  logic [ECW-1:0]         elem_count_r;
  logic signed [PS_W-1:0] ps_r;

  // Group stage
  logic                   g_valid_r;
  logic signed [PS_W-1:0] g_ps_r;
  logic [GIW-1:0]         group_index_r;
  dot_t                   total_r;

  // Result register
  logic out_valid_r;
  dot_t dot_r;

  logic [SZW-1:0]           size_eff;
  logic [GCW-1:0]           cnt_eff;
  logic [SZW-1:0]           elem_inc;
  logic                     grp_done;
  logic                     s1_move;
  logic [GCW-1:0]           gi_inc;
  logic                     emit;
  logic                     g_take;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAR_W-1:0]  offs;
  logic signed [TERM_W-1:0] term;
  logic signed [PS_W-1:0]   ps_sum;
  logic                     neg;
  logic [PS_W:0]            ps_ext;
  logic [PS_W:0]            mag;
  logic [PS_W+1:0]          rnd;
  logic [QD_W-1:0]          qd;
  logic [SZW-1:0]           qmag;
  logic signed [SZW:0]      qs;
  dot_t                     q_ext;
  dot_t                     total_sum;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r  <= GS_W'(1);
      group_count_r <= GC_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GROUP_SIZE:  group_size_r  <= cfg_wdata[GS_W-1:0];
        REG_GROUP_COUNT: group_count_r <= cfg_wdata[GC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp register values to their working ranges
  always_comb begin
    if (group_size_r == '0) begin
      size_eff = SZW'(1);
    end else if (int'(group_size_r) > MAX_GROUP) begin
      size_eff = SZW'(MAX_GROUP);
    end else begin
      size_eff = SZW'(group_size_r);
    end
    if (group_count_r == '0) begin
      cnt_eff = GCW'(1);
    end else if (int'(group_count_r) > MAX_GROUPS) begin
      cnt_eff = GCW'(MAX_GROUPS);
    end else begin
      cnt_eff = GCW'(group_count_r);
    end
  end

  // Flow control: stall only where a full register cannot drain
  assign elem_inc = SZW'(elem_count_r) + SZW'(1);
  assign grp_done = (elem_inc >= size_eff);
  assign gi_inc   = GCW'(group_index_r) + GCW'(1);
  assign emit     = (gi_inc >= cnt_eff);
  assign g_take   = g_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign s1_move  = v1_r && (!grp_done || !g_valid_r || g_take);
  assign in_ch.ready = !v1_r || s1_move;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      v1_r <= 1'b1;
    end else if (s1_move) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_r  <= in_ch.activation;
      w_r  <= in_ch.weight_value;
      vp_r <= in_ch.var_plus;
      vm_r <= in_ch.var_minus;
    end
  end

  // Product, offset by sign, and partial sum
  always_comb begin
    prod   = a_r * w_r;
    offs   = (prod > 0) ? vp_r : vm_r;
    term   = (TERM_W'(prod) <<< FRAC_BITS) + TERM_W'(offs);
    ps_sum = ps_r + PS_W'(term);
  end

  // Advance the accumulator; hand a finished group to the next stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_count_r <= '0;
      ps_r         <= '0;
      g_valid_r    <= 1'b0;
    end else begin
      if (s1_move) begin
        if (grp_done) begin
          elem_count_r <= '0;
          ps_r         <= '0;
        end else begin
          elem_count_r <= elem_inc[ECW-1:0];
          ps_r         <= ps_sum;
        end
      end
      if (s1_move && grp_done) begin
        g_valid_r <= 1'b1;
      end else if (g_take) begin
        g_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && grp_done) begin
      g_ps_r <= ps_sum;
    end
  end

  // Quantize: halve, round half away from zero, double, clamp to size
  always_comb begin
    neg    = g_ps_r[PS_W-1];
    ps_ext = {g_ps_r[PS_W-1], g_ps_r};
    mag    = neg ? (~ps_ext + 1'b1) : ps_ext;
    rnd    = {1'b0, mag} + (PS_W+2)'(2 ** FRAC_BITS);
    qd     = {rnd[PS_W+1:FRAC_BITS+1], 1'b0};
    qmag   = (qd > QD_W'(size_eff)) ? size_eff : qd[SZW-1:0];
    if (size_eff == SZW'(1)) begin
      qs = neg ? -(SZW+1)'(1) : (SZW+1)'(1);
    end else begin
      qs = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
    q_ext     = DOT_W'(qs);
    total_sum = total_r + q_ext;
  end

  // Add the group into the total; restart after the last group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_index_r <= '0;
      total_r       <= '0;
    end else if (g_take) begin
      if (emit) begin
        group_index_r <= '0;
        total_r       <= '0;
      end else begin
        group_index_r <= gi_inc[GIW-1:0];
        total_r       <= total_sum;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (g_take && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (g_take && emit) begin
      dot_r <= total_sum;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.dot_value = dot_r;

`ifndef SYNTH
  // A finished group waits unchanged while it cannot drain
  a_group_hold: assert property (@(posedge clk) disable iff (!rst_n)
    g_valid_r && !g_take |=> g_valid_r && $stable(g_ps_r))
    else $error("group register changed while stalled");

  // Closing a group clears the accumulator
  a_group_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && grp_done |=> elem_count_r == '0 && ps_r == '0)
    else $error("accumulator not cleared after group");

  // A new result only comes from the last group of a set
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(g_take && emit))
    else $error("result appeared without a closing group");

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !(g_take && emit))
    else $error("pending result overwritten");
`endif

endmodule
